### rtl/mmwd_pkg.sv
package mmwd_pkg;

  // Display segments per loop and sample format.
  localparam int SEGMENTS    = 2048;
  localparam int SEG_BITS    = $clog2(SEGMENTS);
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS    = 24;
  localparam int ACC_BITS    = LEN_BITS + SEG_BITS;
  localparam int MAX_BURST   = 64;
  localparam int BURST_BITS  = $clog2(MAX_BURST) + 1;

  // Shortest loop; shorter lengths saturate to it.
  localparam int MIN_LOOP = (SEGMENTS + 63) / 64;
  localparam logic [LEN_BITS-1:0] RESET_LOOP = LEN_BITS'(2048);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the sample of an input transfer
    logic fold;      // fold the held sample into the running extremes
    logic emit;      // load the output register with the finished segment
    logic step_acc;  // advance the segment start accumulator by one length
    logic step_end;  // work out the next segment end and refold if it starts here
    logic finish;    // advance the sample position or restart the loop
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seg_done;  // the current segment ends at this sample
    logic out_free;  // the output register can take a result
  } stat_t;

  // Effective loop length.
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] l);
    logic [LEN_BITS-1:0] r;
    r = (l < LEN_BITS'(MIN_LOOP)) ? LEN_BITS'(MIN_LOOP) : l;
    return r;
  endfunction

  // End of segment zero: L / SEGMENTS, at least one sample.
  function automatic logic [LEN_BITS-1:0] first_end(input logic [LEN_BITS-1:0] l);
    logic [LEN_BITS-1:0] en;
    en = l >> SEG_BITS;
    return (en == '0) ? LEN_BITS'(1) : en;
  endfunction

endpackage

### rtl/mmwd_ctrl.sv
module mmwd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mmwd_pkg::stat_t stat,
  output mmwd_pkg::cmd_t  cmd
);
  import mmwd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FOLD   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_STEPA  = 3'd4;
  localparam logic [2:0] ST_STEPB  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        state_next = stat.seg_done ? ST_EMIT : ST_FINISH;
      end
      ST_CHECK: begin
        state_next = stat.seg_done ? ST_EMIT : ST_FINISH;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_STEPA;
        end
      end
      ST_STEPA: begin
        cmd.step_acc = 1'b1;
        state_next = ST_STEPB;
      end
      ST_STEPB: begin
        cmd.step_end = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/mmwd_datapath.sv
module mmwd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  mmwd_pkg::cmd_t                     cmd,
  output mmwd_pkg::stat_t                    stat,
  input  logic [mmwd_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic [mmwd_pkg::LEN_BITS-1:0]      loop_samples,
  input  logic                               cfg_we,
  input  logic [mmwd_pkg::LEN_BITS-1:0]      cfg_len,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [mmwd_pkg::SEG_BITS-1:0]      out_index,
  output logic [mmwd_pkg::SAMPLE_BITS-1:0]   out_min,
  output logic [mmwd_pkg::SAMPLE_BITS-2:0]   out_max,
  output logic [mmwd_pkg::SAMPLE_BITS-1:0]   out_peak,
  output logic                               out_last
);
  import mmwd_pkg::*;

  logic [SAMPLE_BITS-1:0] held;
  logic [LEN_BITS-1:0]    pos;
  logic [SEG_BITS:0]      cur;
  logic [LEN_BITS-1:0]    seg_end;
  logic [ACC_BITS-1:0]    acc;
  logic [SAMPLE_BITS-2:0] run_pos;
  logic [SAMPLE_BITS-1:0] run_neg;
  logic [SAMPLE_BITS-1:0] peak;
  logic [BURST_BITS-1:0]  burst;

  logic [LEN_BITS-1:0]    len;
  logic [SAMPLE_BITS-1:0] neg_mag;
  logic [SAMPLE_BITS-2:0] fold_pos;
  logic [SAMPLE_BITS-1:0] fold_neg;
  logic [SAMPLE_BITS-1:0] peak_a;
  logic [SAMPLE_BITS-1:0] peak_next;
  logic [ACC_BITS-1:0]    acc_end;
  logic [LEN_BITS-1:0]    new_start;
  logic [LEN_BITS-1:0]    new_end;
  logic [LEN_BITS-1:0]    seg_end_next;
  logic                   loop_done;

  assign len = eff_len(loop_samples);
  assign loop_done = cur[SEG_BITS];

  // Fold the held sample into the running extremes.
  assign neg_mag = SAMPLE_BITS'(0) - held;
  always_comb begin
    fold_pos = run_pos;
    fold_neg = run_neg;
    if (held[SAMPLE_BITS-1]) begin
      if (neg_mag > run_neg) begin
        fold_neg = neg_mag;
      end
    end else if (held[SAMPLE_BITS-2:0] > run_pos) begin
      fold_pos = held[SAMPLE_BITS-2:0];
    end
  end

  // Loop peak including the segment being emitted.
  assign peak_a = ({1'b0, run_pos} > peak) ? {1'b0, run_pos} : peak;
  assign peak_next = (run_neg > peak_a) ? run_neg : peak_a;

  // Next segment bounds: acc holds cur * L after the accumulator step.
  assign acc_end = acc + ACC_BITS'(len);
  assign new_start = acc[ACC_BITS-1:SEG_BITS];
  assign new_end = acc_end[ACC_BITS-1:SEG_BITS];
  assign seg_end_next = (new_end <= new_start) ? new_start + LEN_BITS'(1) : new_end;

  // Status for the controller.
  assign stat.seg_done = !loop_done && (burst < BURST_BITS'(MAX_BURST)) &&
                         ({1'b0, seg_end} == ({1'b0, pos} + (LEN_BITS + 1)'(1)));
  assign stat.out_free = !out_valid || out_ready;

  // Loop state.
  always_ff @(posedge clk) begin
    if (rst || cfg_we || (cmd.finish && loop_done)) begin
      pos     <= '0;
      cur     <= '0;
      acc     <= '0;
      run_pos <= '0;
      run_neg <= '0;
      peak    <= '0;
      burst   <= '0;
      if (rst) begin
        seg_end <= first_end(RESET_LOOP);
      end else if (cfg_we) begin
        seg_end <= first_end(eff_len(cfg_len));
      end else begin
        seg_end <= first_end(len);
      end
    end else begin
      if (cmd.capture) begin
        burst <= '0;
      end
      if (cmd.fold) begin
        run_pos <= fold_pos;
        run_neg <= fold_neg;
      end
      if (cmd.emit) begin
        peak    <= peak_next;
        run_pos <= '0;
        run_neg <= '0;
        cur     <= cur + (SEG_BITS + 1)'(1);
        burst   <= burst + BURST_BITS'(1);
      end
      if (cmd.step_acc) begin
        acc <= acc + ACC_BITS'(len);
      end
      if (cmd.step_end) begin
        seg_end <= seg_end_next;
        if (new_start <= pos) begin
          run_pos <= fold_pos;
          run_neg <= fold_neg;
        end
      end
      if (cmd.finish) begin
        pos <= pos + LEN_BITS'(1);
      end
    end
  end

  // Held sample.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held <= sample;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: result fields.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= cur[SEG_BITS-1:0];
      out_min   <= SAMPLE_BITS'(0) - run_neg;
      out_max   <= run_pos;
      out_peak  <= peak_next;
      out_last  <= (cur == (SEG_BITS + 1)'(SEGMENTS - 1));
    end
  end

endmodule

### rtl/minmax_waveform_decimator.sv
// Channel   Direction  Payload
// s_*       in         tdata[15:0] sample
// m_*       out        tdata[10:0] segment_index, [26:11] segment_min,
//                      [41:27] segment_max, [57:42] peak_level; tlast last_segment
// APB       in/out     register 0 at byte 0: loop_samples[23:0]
//
// A sample that completes no segment goes through the fold and finish states before
// the next transfer; each segment it completes adds an emit state and the steps of the
// shared segment bound accumulator (start step, end step, check), and waits on the single
// output register.
// A result waiting at m_* stalls only at the emission of the following segment; s_tready stays low while it waits.
// Reset is synchronous on rst; it sets loop_samples to 2048 and restarts the loop.
// A write of loop_samples also restarts the loop.
module minmax_waveform_decimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [10:0] segment_index, [26:11] segment_min,
                                 // [41:27] segment_max, [57:42] peak_level, [63:58] zero
  output logic        m_tlast,   // last_segment
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mmwd_pkg::*;

  localparam logic REG_LOOP = 1'b0;

  logic [LEN_BITS-1:0]    loop_samples;
  logic                   cfg_we;
  cmd_t                   cmd;
  stat_t                  stat;
  logic [SEG_BITS-1:0]    out_index;
  logic [SAMPLE_BITS-1:0] out_min;
  logic [SAMPLE_BITS-2:0] out_max;
  logic [SAMPLE_BITS-1:0] out_peak;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LOOP);
  assign prdata = (paddr[2] == REG_LOOP) ? {8'b0, loop_samples} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_samples <= RESET_LOOP;
    end else if (cfg_we) begin
      loop_samples <= pwdata[LEN_BITS-1:0];
    end
  end

  mmwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmwd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (s_tdata),
    .loop_samples (loop_samples),
    .cfg_we       (cfg_we),
    .cfg_len      (pwdata[LEN_BITS-1:0]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_index    (out_index),
    .out_min      (out_min),
    .out_max      (out_max),
    .out_peak     (out_peak),
    .out_last     (m_tlast)
  );

  // Pack the result fields, lowest first.
  assign m_tdata = {6'b0, out_peak, out_max, out_min, out_index};

endmodule

### rtl/mmwd_checker.sv
module mmwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // The final segment of a loop always carries the highest index.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[10:0] == 11'h7FF)
    else $error("last segment with wrong index");

  // The loop peak covers the segment maximum and the segment minimum.
  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[57:42] >= {1'b0, m_tdata[41:27]}) &&
                 (m_tdata[57:42] >= (16'd0 - m_tdata[26:11])))
    else $error("peak below segment extremes");

  // A segment minimum is never positive.
  a_min_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[26] || (m_tdata[26:11] == 16'd0))
    else $error("positive segment minimum");

  // After reset the block waits for a sample with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // A stalled result is held.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  logic unused_ok;
  assign unused_ok = ^{s_tvalid, s_tdata, psel, penable, pwrite, paddr, pwdata, prdata, pready};

endmodule

bind minmax_waveform_decimator mmwd_checker u_mmwd_checker (.*);

### verif/minmax_waveform_decimator_checker.sv
`timescale 1ns / 1ps

module minmax_waveform_decimator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          outstanding,
  output int          failures,
  output int          segments_seen
);
  import mmwd_pkg::*;

  // Register index of loop_samples in the register map.
  localparam int LOOP_SAMPLES_IDX = 0;
  localparam int REPORT_LIMIT     = 10;

  // One finished display segment as it should leave the block.
  typedef struct packed {
    logic [SEG_BITS-1:0]    index;
    logic [SAMPLE_BITS-1:0] seg_min;
    logic [SAMPLE_BITS-2:0] seg_max;
    logic [SAMPLE_BITS-1:0] peak;
    logic                   last;
  } segment_t;

  // Shadow copy of the configuration and of the decimation state.
  logic [LEN_BITS-1:0]    loop_len = RESET_LOOP;
  longint unsigned        position;
  int unsigned            segment;
  longint unsigned        segment_end;
  logic [SAMPLE_BITS-2:0] max_pos;
  logic [SAMPLE_BITS-1:0] max_neg;
  logic [SAMPLE_BITS-1:0] loop_level;
  segment_t               expected_segments[$];
  int                     mismatches = 0;
  int                     seen = 0;

  function automatic longint unsigned effective_len();
    return (loop_len < LEN_BITS'(MIN_LOOP)) ? longint'(MIN_LOOP) : longint'(loop_len);
  endfunction

  function automatic longint unsigned start_of(input longint unsigned s);
    return (s * effective_len()) / SEGMENTS;
  endfunction

  // An empty segment is widened to the one sample at its start.
  function automatic longint unsigned end_of(input longint unsigned s);
    longint unsigned st;
    longint unsigned en;
    st = start_of(s);
    en = ((s + 1) * effective_len()) / SEGMENTS;
    return (en <= st) ? st + 1 : en;
  endfunction

  function automatic void restart_loop();
    position    = 0;
    segment     = 0;
    segment_end = end_of(0);
    max_pos     = '0;
    max_neg     = '0;
    loop_level  = '0;
  endfunction

  // Full scale negative gives a magnitude of 32768, which still fits 16 bits.
  function automatic void fold_in(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS:0] mag;
    if (raw[SAMPLE_BITS-1]) begin
      mag = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, raw};
      if (mag[SAMPLE_BITS-1:0] > max_neg) max_neg = mag[SAMPLE_BITS-1:0];
    end else if (raw[SAMPLE_BITS-2:0] > max_pos) begin
      max_pos = raw[SAMPLE_BITS-2:0];
    end
  endfunction

  // Fold one sample and queue every segment that it completes.
  function automatic void decimate_sample(input logic [SAMPLE_BITS-1:0] raw);
    segment_t r;
    int       n;
    n = 0;
    fold_in(raw);
    while (segment < SEGMENTS && n < MAX_BURST && segment_end == position + 1) begin
      if (max_pos > loop_level) loop_level = max_pos;
      if (max_neg > loop_level) loop_level = max_neg;
      r.index   = SEG_BITS'(segment);
      r.seg_min = '0 - max_neg;
      r.seg_max = max_pos;
      r.peak    = loop_level;
      r.last    = (segment == SEGMENTS - 1);
      expected_segments = {expected_segments, r};
      n++;
      max_pos = '0;
      max_neg = '0;
      segment++;
      if (segment < SEGMENTS) begin
        segment_end = end_of(segment);
        // A segment that starts at this very sample sees it too.
        if (start_of(segment) <= position) fold_in(raw);
      end
    end
    if (segment >= SEGMENTS) restart_loop();
    else position = (position + 1) & 64'hFF_FFFF;
  endfunction

  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
  endfunction

  function automatic string describe(input segment_t r);
    return $sformatf("idx=%0d min=%0d max=%0d peak=%0d last=%0b",
                     r.index, $signed(r.seg_min), r.seg_max, r.peak, r.last);
  endfunction

  // Watch the register port and both stream channels.
  always @(posedge clk) begin
    segment_t want;
    segment_t got;
    if (rst) begin
      loop_len = RESET_LOOP;
      restart_loop();
      expected_segments.delete();
    end else begin
      if (psel && penable && pready && (paddr >> 2) == LOOP_SAMPLES_IDX) begin
        if (pwrite) begin
          loop_len = pwdata[LEN_BITS-1:0];
          restart_loop();
        end else if (prdata !== {{(32-LEN_BITS){1'b0}}, loop_len}) begin
          note_failure($sformatf("loop_samples read: expected %0d, got %0h",
                                 loop_len, prdata));
        end
      end

      if (s_tvalid && s_tready) decimate_sample(s_tdata);

      if (m_tvalid && m_tready) begin
        seen++;
        got.index   = m_tdata[10:0];
        got.seg_min = m_tdata[26:11];
        got.seg_max = m_tdata[41:27];
        got.peak    = m_tdata[57:42];
        got.last    = m_tlast;
        if (expected_segments.size() == 0) begin
          note_failure({"unexpected segment transfer: ", describe(got)});
        end else begin
          want = expected_segments.pop_front();
          if (got !== want || m_tdata[63:58] !== '0) begin
            note_failure({"segment mismatch: expected ", describe(want),
                          ", got ", describe(got),
                          $sformatf(" pad=%0h", m_tdata[63:58])});
          end
        end
      end
    end
    outstanding   <= expected_segments.size();
    failures      <= mismatches;
    segments_seen <= seen;
  end

endmodule

### verif/minmax_waveform_decimator_test.sv
`timescale 1ns / 1ps

module minmax_waveform_decimator_test;
  import mmwd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;

  // Register map: loop_samples at byte 0; byte 4 holds no register.
  localparam logic [2:0] LOOP_SAMPLES_ADDR = 3'd0;
  localparam logic [2:0] UNMAPPED_ADDR     = 3'd4;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int outstanding;
  int failures;
  int segments_seen;
  int samples_sent  = 0;
  int lengths_used  = 1;
  int cycles        = 0;
  int results_taken = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  bit hold_done     = 1'b0;
  bit quiet         = 1'b0;

  // Corner samples, one segment each at the reset length.
  logic [15:0] corner_samples [24] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h8001,
    16'h7FFE, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA, 16'h0100,
    16'hFF00, 16'h00FF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFE,
    16'h0002, 16'h3FFF, 16'hBFFF, 16'h8000, 16'h8000, 16'h7FFF
  };

  minmax_waveform_decimator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  minmax_waveform_decimator_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .outstanding   (outstanding),
    .failures      (failures),
    .segments_seen (segments_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL minmax_waveform_decimator");
      $finish;
    end
  end

  // Segment receiver: random stall bursts and one long hold-off so that the
  // output register fills and the block stops taking samples.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_taken++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Mostly full-range samples, with extremes and small magnitudes mixed in.
  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2, 3:    v = 16'($signed($urandom_range(0, 512)) - 256);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Offer one sample, after an optional idle burst, until it is transferred.
  task automatic send_sample(input logic [15:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  task automatic run_samples(input int count);
    repeat (count) send_sample(pick_sample());
    s_tvalid <= 1'b0;
  endtask

  // Wait until every expected segment is out and the block has gone quiet.
  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program a register with junk in the unused upper bits, then read back loop_samples.
  task automatic program_reg(input logic [2:0] addr, input logic [23:0] value);
    logic [7:0] junk;
    junk = 8'($urandom);
    settle();
    apb_access(1'b1, addr, {junk, value});
    apb_access(1'b0, LOOP_SAMPLES_ADDR, '0);
    if (addr == LOOP_SAMPLES_ADDR) lengths_used++;
  endtask

  initial begin
    logic [23:0] len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length: every sample closes exactly one segment.
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    s_tvalid <= 1'b0;

    // Zero saturates to the shortest loop; 40 samples wrap past its end.
    program_reg(LOOP_SAMPLES_ADDR, 24'd0);
    run_samples(40);

    // A write to the unmapped address must leave the loop running.
    program_reg(UNMAPPED_ADDR, 24'h00_0005);
    run_samples(10);

    // Longest loop: no segment can finish within a few samples.
    program_reg(LOOP_SAMPLES_ADDR, 24'hFF_FFFF);
    run_samples(8);

    program_reg(LOOP_SAMPLES_ADDR, 24'd31);
    run_samples(36);
    program_reg(LOOP_SAMPLES_ADDR, 24'd33);
    run_samples(35);

    // Random loop lengths; the last phase runs without any idling.
    for (int p = 0; p < 3; p++) begin
      case ($urandom_range(0, 2))
        0:       len = 24'($urandom_range(1, 31));
        1:       len = 24'($urandom_range(32, 200));
        default: len = 24'($urandom_range(1000, 5000));
      endcase
      if (p == 2) quiet <= 1'b1;
      program_reg(LOOP_SAMPLES_ADDR, len);
      run_samples($urandom_range(18, 26));
    end

    settle();
    $display("Sent %0d samples under %0d loop lengths; %0d segment results checked.",
             samples_sent, lengths_used, segments_seen);
    $display({"Included full-scale samples, saturated loops, an unmapped write",
              " and a %0d-cycle output hold-off."}, HOLD_CYCLES);
    if (failures == 0 && outstanding == 0) begin
      $display("PASS minmax_waveform_decimator");
    end else begin
      $display("FAIL minmax_waveform_decimator");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mmwd_pkg.sv
rtl/mmwd_ctrl.sv
rtl/mmwd_datapath.sv
rtl/minmax_waveform_decimator.sv
rtl/mmwd_checker.sv
verif/minmax_waveform_decimator_checker.sv
verif/minmax_waveform_decimator_test.sv
